/* design/kwlc_pkg.sv */
// ----------------------------------------------------------------------------
// kwlc_pkg: shared types and constants for the keyword and literal counter
// Keyword table, byte codes, queue depths and the item and report row types.
// ----------------------------------------------------------------------------
package kwlc_pkg;

    // Defaults for the top level parameters
    localparam int DEF_CHUNK_LIMIT     = 1023;
    localparam int DEF_KEYWORD_COUNT   = 17;
    localparam int DEF_MAX_KEYWORD_LEN = 8;
    localparam int DEF_COUNT_BITS      = 32;
    localparam int DEF_IN_DEPTH        = 2;
    localparam int DEF_OUT_DEPTH       = 2;

    // Fixed field widths
    localparam int OUT_W = 32;
    localparam int IDX_W = 5;
    localparam int POS_W = 10;

    // Byte codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;

    // Keyword table, right-aligned text with lengths
    localparam int KW_SLOTS     = 17;
    localparam int KW_MAX_CHARS = 16;

    localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [KW_SLOTS] = '{
        "strlen", "strcpy", "strncpy", "strcat", "strncat", "strcmp",
        "strncmp", "strchr", "strrchr", "strstr", "strtok", "sprintf",
        "snprintf", "sscanf", "fgets", "puts", "gets"
    };

    localparam int KW_LEN [KW_SLOTS] = '{
        6, 6, 7, 6, 7, 6, 7, 6, 7, 6, 6, 7, 8, 6, 5, 4, 4
    };

    // Character j (from the start) of keyword k, zero past its end
    function automatic logic [7:0] kw_char(input int k, input int j);
        logic [7:0] c;
        c = 8'h00;
        if (j < KW_LEN[k])
        begin
            c = KW_TEXT[k][8*(KW_LEN[k]-1-j) +: 8];
        end
        return c;
    endfunction

    // One classified input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        logic       is_quote;
        logic       is_zero;
        logic       is_newline;
    } item_t;

    // One report row
    typedef struct packed {
        logic [IDX_W-1:0] keyword_index;
        logic [OUT_W-1:0] keyword_hits;
        logic [OUT_W-1:0] literal_total;
        logic [OUT_W-1:0] literal_bytes;
        logic [OUT_W-1:0] hits_sum;
        logic             final_row;
    } out_row_t;

endpackage

/* design/kwlc_fifo.sv */
// ----------------------------------------------------------------------------
// kwlc_fifo: small register queue
// First-in first-out buffer with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module kwlc_fifo
    import kwlc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEF_IN_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_data = store[rd_ptr_reg];

    // Advance pointers with wrap and track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold entry data, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* design/kwlc_front.sv */
// ----------------------------------------------------------------------------
// kwlc_front: input stage
// Accepts text items, tags quote, zero and newline bytes, and queues them.
// ----------------------------------------------------------------------------
module kwlc_front
    import kwlc_pkg::*;
#(
    parameter int IN_DEPTH = DEF_IN_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       full,
    output item_t      item,
    output logic       item_valid,
    input  logic       item_pop
);

    item_t                 tagged_item;
    logic [$bits(item_t)-1:0] q_data;
    logic                  q_empty;

    // Classify the incoming byte
    always_comb
    begin
        tagged_item.text_byte   = text_byte;
        tagged_item.end_of_text = end_of_text;
        tagged_item.is_quote    = (text_byte == CHAR_QUOTE);
        tagged_item.is_zero     = (text_byte == CHAR_NUL);
        tagged_item.is_newline  = (text_byte == CHAR_NL);
    end

    kwlc_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (IN_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (tagged_item),
        .full    (full),
        .pop     (item_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    assign item       = item_t'(q_data);
    assign item_valid = ~q_empty;

endmodule

/* design/kwlc_back.sv */
// ----------------------------------------------------------------------------
// kwlc_back: scan and report engine
// Runs one shift-and matcher per keyword, pairs quotes, tracks chunks, and
// walks the report rows on an end item.
// ----------------------------------------------------------------------------
module kwlc_back
    import kwlc_pkg::*;
#(
    parameter int CHUNK_LIMIT     = DEF_CHUNK_LIMIT,
    parameter int KEYWORD_COUNT   = DEF_KEYWORD_COUNT,
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN,
    parameter int COUNT_BITS      = DEF_COUNT_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  item_t    item,
    input  logic     item_valid,
    output logic     item_pop,
    output out_row_t row,
    output logic     row_push,
    input  logic     row_full
);

    localparam int KI_W  = (KEYWORD_COUNT > 1) ? $clog2(KEYWORD_COUNT) : 1;
    localparam int PC_W  = $clog2(KEYWORD_COUNT + 1);
    localparam int SUM_W = ((COUNT_BITS > POS_W) ? COUNT_BITS : POS_W) + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_SCAN   = 2'b01,
        ST_REPORT = 2'b10
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [KI_W-1:0] idx_reg, idx_next;

    logic [MAX_KEYWORD_LEN-1:0] partial_reg [KEYWORD_COUNT];
    logic [MAX_KEYWORD_LEN-1:0] partial_next [KEYWORD_COUNT];
    logic [MAX_KEYWORD_LEN-1:0] step_bits [KEYWORD_COUNT];
    logic [COUNT_BITS-1:0]      count_reg [KEYWORD_COUNT];
    logic [COUNT_BITS-1:0]      count_next [KEYWORD_COUNT];
    logic [KEYWORD_COUNT-1:0]   complete;
    logic [KEYWORD_COUNT-1:0]   bump;

    logic                  inside_reg, inside_next;
    logic [POS_W-1:0]      olen_reg, olen_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  stopped_reg, stopped_next;
    logic [COUNT_BITS-1:0] pair_count_reg, pair_count_next;
    logic [COUNT_BITS-1:0] pair_bytes_reg, pair_bytes_next;
    logic [COUNT_BITS-1:0] sum_reg, sum_next;

    logic [PC_W-1:0]  bump_cnt;
    logic [SUM_W-1:0] pair_count_add, pair_bytes_add, sum_add;
    logic [POS_W-1:0] pos_inc;
    logic             byte_go, end_go;

    // Per-keyword shift-and step on the head byte
    for (genvar k = 0; k < KEYWORD_COUNT; k++)
    begin : g_kw
        localparam int LEN = (KW_LEN[k] > MAX_KEYWORD_LEN) ? MAX_KEYWORD_LEN : KW_LEN[k];
        for (genvar j = 0; j < MAX_KEYWORD_LEN; j++)
        begin : g_bit
            localparam logic [7:0] CH = kw_char(k, j);
            if (j >= LEN)
            begin : g_off
                assign step_bits[k][j] = 1'b0;
            end
            else if (j == 0)
            begin : g_first
                assign step_bits[k][j] = (item.text_byte == CH);
            end
            else
            begin : g_next
                assign step_bits[k][j] = partial_reg[k][j-1] & (item.text_byte == CH);
            end
        end
        assign complete[k] = step_bits[k][LEN-1];
        assign bump[k]     = complete[k] & (count_reg[k] != CNT_MAX);
    end

    // Count keyword increments on this byte
    always_comb
    begin
        bump_cnt = '0;
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            bump_cnt = bump_cnt + PC_W'(bump[k]);
        end
    end

    assign pair_count_add = SUM_W'(pair_count_reg) + SUM_W'(1);
    assign pair_bytes_add = SUM_W'(pair_bytes_reg) + SUM_W'(olen_reg);
    assign sum_add        = SUM_W'(sum_reg) + SUM_W'(bump_cnt);
    assign pos_inc        = pos_reg + 1'b1;

    assign byte_go = (state_reg == ST_SCAN) & item_valid & ~item.end_of_text;
    assign end_go  = (state_reg == ST_SCAN) & item_valid & item.end_of_text;

    // Next-state logic for scanning and reporting
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        inside_next     = inside_reg;
        olen_next       = olen_reg;
        pos_next        = pos_reg;
        stopped_next    = stopped_reg;
        pair_count_next = pair_count_reg;
        pair_bytes_next = pair_bytes_reg;
        sum_next        = sum_reg;
        item_pop        = 1'b0;
        row_push        = 1'b0;
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            partial_next[k] = partial_reg[k];
            count_next[k]   = count_reg[k];
        end

        case (state_reg)
            ST_SCAN:
            begin
                if (byte_go)
                begin
                    item_pop = 1'b1;
                    if (!stopped_reg)
                    begin
                        if (item.is_zero)
                        begin
                            // Stop matching for the rest of the chunk
                            stopped_next = 1'b1;
                            inside_next  = 1'b0;
                            olen_next    = '0;
                            for (int k = 0; k < KEYWORD_COUNT; k++)
                            begin
                                partial_next[k] = '0;
                            end
                        end
                        else
                        begin
                            // Pair quotes left to right
                            if (item.is_quote)
                            begin
                                if (inside_reg)
                                begin
                                    pair_count_next = (pair_count_add > SUM_W'(CNT_MAX)) ?
                                                      CNT_MAX : COUNT_BITS'(pair_count_add);
                                    pair_bytes_next = (pair_bytes_add > SUM_W'(CNT_MAX)) ?
                                                      CNT_MAX : COUNT_BITS'(pair_bytes_add);
                                    inside_next = 1'b0;
                                end
                                else
                                begin
                                    inside_next = 1'b1;
                                end
                                olen_next = '0;
                            end
                            else if (inside_reg)
                            begin
                                olen_next = olen_reg + 1'b1;
                            end
                            // Advance matchers, drop a matcher after a full hit
                            for (int k = 0; k < KEYWORD_COUNT; k++)
                            begin
                                partial_next[k] = complete[k] ? '0 : step_bits[k];
                                if (bump[k])
                                begin
                                    count_next[k] = count_reg[k] + 1'b1;
                                end
                            end
                            sum_next = (sum_add > SUM_W'(CNT_MAX)) ?
                                       CNT_MAX : COUNT_BITS'(sum_add);
                        end
                    end
                    // Close the chunk on newline or length limit
                    pos_next = pos_inc;
                    if (item.is_newline || (pos_inc >= POS_W'(CHUNK_LIMIT)))
                    begin
                        pos_next     = '0;
                        stopped_next = 1'b0;
                        inside_next  = 1'b0;
                        olen_next    = '0;
                        for (int k = 0; k < KEYWORD_COUNT; k++)
                        begin
                            partial_next[k] = '0;
                        end
                    end
                end
                else if (end_go)
                begin
                    item_pop   = 1'b1;
                    state_next = ST_REPORT;
                    idx_next   = '0;
                end
            end

            ST_REPORT:
            begin
                if (!row_full)
                begin
                    row_push = 1'b1;
                    if (idx_reg == KI_W'(KEYWORD_COUNT - 1))
                    begin
                        // Last row out: clear everything
                        state_next      = ST_SCAN;
                        idx_next        = '0;
                        inside_next     = 1'b0;
                        olen_next       = '0;
                        pos_next        = '0;
                        stopped_next    = 1'b0;
                        pair_count_next = '0;
                        pair_bytes_next = '0;
                        sum_next        = '0;
                        for (int k = 0; k < KEYWORD_COUNT; k++)
                        begin
                            partial_next[k] = '0;
                            count_next[k]   = '0;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_SCAN;
            end
        endcase
    end

    // Build the current report row
    always_comb
    begin
        row.keyword_index = IDX_W'(idx_reg);
        row.keyword_hits  = OUT_W'(count_reg[idx_reg]);
        row.literal_total = OUT_W'(pair_count_reg);
        row.literal_bytes = OUT_W'(pair_bytes_reg);
        row.hits_sum      = OUT_W'(sum_reg);
        row.final_row     = (idx_reg == KI_W'(KEYWORD_COUNT - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SCAN;
            idx_reg        <= '0;
            inside_reg     <= 1'b0;
            olen_reg       <= '0;
            pos_reg        <= '0;
            stopped_reg    <= 1'b0;
            pair_count_reg <= '0;
            pair_bytes_reg <= '0;
            sum_reg        <= '0;
            for (int k = 0; k < KEYWORD_COUNT; k++)
            begin
                partial_reg[k] <= '0;
                count_reg[k]   <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            inside_reg     <= inside_next;
            olen_reg       <= olen_next;
            pos_reg        <= pos_next;
            stopped_reg    <= stopped_next;
            pair_count_reg <= pair_count_next;
            pair_bytes_reg <= pair_bytes_next;
            sum_reg        <= sum_next;
            for (int k = 0; k < KEYWORD_COUNT; k++)
            begin
                partial_reg[k] <= partial_next[k];
                count_reg[k]   <= count_next[k];
            end
        end
    end

endmodule

/* design/keyword_and_literal_counter.sv */
// ----------------------------------------------------------------------------
// keyword_and_literal_counter: keyword and quoted-literal counter
// Counts fixed keywords and closed quote pairs in a text byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive text_byte/end_of_text with push; a transfer happens
//   when push is high and full is low. A byte item yields no result; an
//   end item yields one row per keyword (KEYWORD_COUNT rows), the last
//   flagged by final_row, and then all counts clear.
//   Result queue: while empty is low the oldest row is on the ports; pop
//   takes it.
//   Throughput: one byte per cycle while the scan engine is not reporting,
//   set by the matcher update in the scan engine. An end item holds the
//   scan engine while it writes its rows, one per cycle while the result
//   queue is not full. Rows enter the result queue once the end item is popped.
//   Stall: when the receiver stops popping, the result queue fills, the
//   report pauses, the input queue fills and full rises; nothing is lost.
//   Reset: all counts, chunk state and both queues clear; no clearing pass.
// ----------------------------------------------------------------------------
module keyword_and_literal_counter
    import kwlc_pkg::*;
#(
    parameter int CHUNK_LIMIT     = DEF_CHUNK_LIMIT,
    parameter int KEYWORD_COUNT   = DEF_KEYWORD_COUNT,
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN,
    parameter int COUNT_BITS      = DEF_COUNT_BITS,
    parameter int IN_DEPTH        = DEF_IN_DEPTH,
    parameter int OUT_DEPTH       = DEF_OUT_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       text_byte,
    input  logic             end_of_text,
    output logic             empty,
    input  logic             pop,
    output logic [IDX_W-1:0] keyword_index,
    output logic [OUT_W-1:0] keyword_hits,
    output logic [OUT_W-1:0] literal_total,
    output logic [OUT_W-1:0] literal_bytes,
    output logic [OUT_W-1:0] hits_sum,
    output logic             final_row
);

    item_t    item;
    logic     item_valid;
    logic     item_pop;
    out_row_t row;
    logic     row_push;
    logic     row_full;
    logic [$bits(out_row_t)-1:0] head_data;
    out_row_t head_row;

    kwlc_front #(
        .IN_DEPTH (IN_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .full        (full),
        .item        (item),
        .item_valid  (item_valid),
        .item_pop    (item_pop)
    );

    kwlc_back #(
        .CHUNK_LIMIT     (CHUNK_LIMIT),
        .KEYWORD_COUNT   (KEYWORD_COUNT),
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
        .COUNT_BITS      (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .row        (row),
        .row_push   (row_push),
        .row_full   (row_full)
    );

    kwlc_fifo #(
        .WIDTH ($bits(out_row_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (row_push),
        .wr_data (row),
        .full    (row_full),
        .pop     (pop),
        .rd_data (head_data),
        .empty   (empty)
    );

    // Split the head row onto the result ports
    assign head_row      = out_row_t'(head_data);
    assign keyword_index = head_row.keyword_index;
    assign keyword_hits  = head_row.keyword_hits;
    assign literal_total = head_row.literal_total;
    assign literal_bytes = head_row.literal_bytes;
    assign hits_sum      = head_row.hits_sum;
    assign final_row     = head_row.final_row;

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: keyword and literal counter testbench
// Streams text bytes and end-of-text items into the counter and predicts
// every report row from its own scan of the stream. A short directed part is
// followed by random text: keywords, run-on keywords, quoted literals, stray
// quotes, zero bytes, newlines and raw noise. Both sides idle at random; the
// receiver stalls long enough to back up the input once, and the sender
// waits for a full drain twice.
// ----------------------------------------------------------------------------
module tb
    import kwlc_pkg::*;
();

    localparam int STALL_CYCLES  = 150;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int TAIL_CYCLES   = 20;
    localparam int ITEM_TARGET   = 310;

    typedef enum int
    {
        SEG_KEYWORD,
        SEG_RUN_ON,
        SEG_LITERAL,
        SEG_LONE_QUOTE,
        SEG_FILLER,
        SEG_NEWLINE,
        SEG_ZERO,
        SEG_NOISE,
        SEG_END
    } segment_kind_e;

    // ------------------------------------------------------------------------
    // Scan predictor and expected report rows
    // ------------------------------------------------------------------------
    class text_tally_board;
        string            keyword_spell [KW_SLOTS];
        bit [DEF_MAX_KEYWORD_LEN-1:0] partial [KW_SLOTS];
        bit [OUT_W-1:0]   hits [KW_SLOTS];
        bit               in_quote;
        bit [POS_W-1:0]   quote_len;
        bit [POS_W-1:0]   chunk_len;
        bit               stopped;
        bit [OUT_W-1:0]   pairs;
        bit [OUT_W-1:0]   pair_len;
        out_row_t         pending_rows [$];
        int               errors;
        int               rows_checked;
        int               bytes_seen;
        int               reports_seen;
        longint           pairs_reported;
        longint           hits_reported;

        function new();
            keyword_spell = '{
                "strlen", "strcpy", "strncpy", "strcat", "strncat", "strcmp",
                "strncmp", "strchr", "strrchr", "strstr", "strtok", "sprintf",
                "snprintf", "sscanf", "fgets", "puts", "gets"
            };
            errors = 0;
            rows_checked = 0;
            bytes_seen = 0;
            reports_seen = 0;
            pairs_reported = 0;
            hits_reported = 0;
            clear_all();
        endfunction

        function bit [OUT_W-1:0] sat_add(bit [OUT_W-1:0] a, bit [OUT_W-1:0] b);
            bit [OUT_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[OUT_W] ? '1 : s[OUT_W-1:0];
        endfunction

        // Drop partial matches and any open quote; start a fresh chunk
        function void close_chunk();
            foreach (partial[k])
                partial[k] = '0;
            in_quote = 1'b0;
            quote_len = '0;
            chunk_len = '0;
            stopped = 1'b0;
        endfunction

        function void clear_all();
            foreach (hits[k])
                hits[k] = '0;
            pairs = '0;
            pair_len = '0;
            close_chunk();
        endfunction

        // Shift-and step for one keyword; clear it after a full match
        function void advance_matcher(int k, bit [7:0] b);
            int n;
            int j;
            bit prev;
            bit [DEF_MAX_KEYWORD_LEN-1:0] nxt;
            n = keyword_spell[k].len();
            if (n > DEF_MAX_KEYWORD_LEN)
                n = DEF_MAX_KEYWORD_LEN;
            nxt = '0;
            for (j = 0; j < n; j++)
            begin
                prev = (j == 0) ? 1'b1 : partial[k][j-1];
                if (prev && keyword_spell[k][j] == b)
                    nxt[j] = 1'b1;
            end
            if (n > 0 && nxt[n-1])
            begin
                hits[k] = sat_add(hits[k], 1);
                nxt = '0;
            end
            partial[k] = nxt;
        endfunction

        // Note one accepted input transfer
        function void absorb_item(bit [7:0] b, bit eot);
            bit [OUT_W-1:0] total;
            out_row_t row;
            if (eot)
            begin
                total = '0;
                foreach (hits[k])
                    total = sat_add(total, hits[k]);
                for (int k = 0; k < DEF_KEYWORD_COUNT; k++)
                begin
                    row.keyword_index = IDX_W'(k);
                    row.keyword_hits  = hits[k];
                    row.literal_total = pairs;
                    row.literal_bytes = pair_len;
                    row.hits_sum      = total;
                    row.final_row     = (k == DEF_KEYWORD_COUNT - 1);
                    pending_rows.push_back(row);
                end
                reports_seen++;
                pairs_reported += pairs;
                hits_reported += total;
                clear_all();
                return;
            end
            bytes_seen++;
            if (!stopped)
            begin
                if (b == CHAR_NUL)
                begin
                    // Zero byte: stop matching for the rest of the chunk
                    stopped = 1'b1;
                    foreach (partial[k])
                        partial[k] = '0;
                    in_quote = 1'b0;
                    quote_len = '0;
                end
                else
                begin
                    if (b == CHAR_QUOTE)
                    begin
                        if (in_quote)
                        begin
                            pairs = sat_add(pairs, 1);
                            pair_len = sat_add(pair_len, OUT_W'(quote_len));
                            in_quote = 1'b0;
                            quote_len = '0;
                        end
                        else
                        begin
                            in_quote = 1'b1;
                            quote_len = '0;
                        end
                    end
                    else if (in_quote)
                    begin
                        quote_len = quote_len + 1'b1;
                    end
                    foreach (partial[k])
                        advance_matcher(k, b);
                end
            end
            chunk_len = chunk_len + 1'b1;
            if (b == CHAR_NL || int'(chunk_len) >= DEF_CHUNK_LIMIT)
                close_chunk();
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        task compare_field(string name, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
            if (got !== want)
                report($sformatf("row %0d %s: got %0h, expected %0h",
                                 rows_checked, name, got, want));
        endtask

        // Check one accepted result transfer against the oldest expectation
        task check_row(logic [IDX_W-1:0] idx, logic [OUT_W-1:0] kw_hits,
                       logic [OUT_W-1:0] lit_total, logic [OUT_W-1:0] lit_bytes,
                       logic [OUT_W-1:0] sum, logic fin);
            out_row_t want;
            if (pending_rows.size() == 0)
            begin
                report($sformatf("report row for keyword %0d with nothing expected", idx));
                return;
            end
            want = pending_rows.pop_front();
            compare_field("keyword_index", OUT_W'(idx), OUT_W'(want.keyword_index));
            compare_field("keyword_hits", kw_hits, want.keyword_hits);
            compare_field("literal_total", lit_total, want.literal_total);
            compare_field("literal_bytes", lit_bytes, want.literal_bytes);
            compare_field("hits_sum", sum, want.hits_sum);
            compare_field("final_row", OUT_W'(fin), OUT_W'(want.final_row));
            rows_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       text_byte = 8'h00;
    logic             end_of_text = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic [IDX_W-1:0] keyword_index;
    logic [OUT_W-1:0] keyword_hits;
    logic [OUT_W-1:0] literal_total;
    logic [OUT_W-1:0] literal_bytes;
    logic [OUT_W-1:0] hits_sum;
    logic             final_row;

    text_tally_board tally = new();

    int  sent_items = 0;
    int  stall_requests = 0;
    int  stall_served = 0;
    int  stall_left = 0;
    int  full_cycles = 0;
    int  quiet_cycles = 0;
    bit  no_idle = 1'b0;
    string filler_pool = "strncpyfgethaoiku ;(),";

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    keyword_and_literal_counter DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .text_byte     (text_byte),
        .end_of_text   (end_of_text),
        .empty         (empty),
        .pop           (pop),
        .keyword_index (keyword_index),
        .keyword_hits  (keyword_hits),
        .literal_total (literal_total),
        .literal_bytes (literal_bytes),
        .hits_sum      (hits_sum),
        .final_row     (final_row)
    );

    // ------------------------------------------------------------------------
    // Receiver: random idling, one long stall on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_served != stall_requests)
        begin
            stall_served++;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= no_idle || ($urandom_range(99) >= 11);
        end
    end

    // Check each result transfer
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            tally.check_row(keyword_index, keyword_hits, literal_total,
                            literal_bytes, hits_sum, final_row);
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run after too long without any transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && full)
                full_cycles++;
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("Timeout: no transfer for %0d cycles", WATCHDOG_MAX);
                $display("keyword_and_literal_counter test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks; each starts and ends at a falling edge
    // ------------------------------------------------------------------------
    task send_item(input logic [7:0] b, input logic eot);
        // Idle at random, with junk on the data lines
        while (!no_idle && $urandom_range(99) < 11)
        begin
            push <= 1'b0;
            text_byte <= 8'($urandom_range(255));
            @(negedge clk);
        end
        push <= 1'b1;
        text_byte <= b;
        end_of_text <= eot;
        // Hold until the transfer happens
        do
            @(posedge clk);
        while (full);
        tally.absorb_item(b, eot);
        sent_items++;
        @(negedge clk);
    endtask

    task send_text(input string s);
        foreach (s[i])
            send_item(s[i], 1'b0);
    endtask

    task send_end();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task send_filler(input int n);
        repeat (n)
            send_item(filler_pool[$urandom_range(filler_pool.len() - 1)], 1'b0);
    endtask

    // Pause the input until every expected row has come back
    task wait_drained();
        push <= 1'b0;
        while (tally.pending_rows.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // One random piece of text
    task send_segment();
        int r;
        int k;
        int cut;
        segment_kind_e kind;
        r = $urandom_range(99);
        if (r < 22)      kind = SEG_KEYWORD;
        else if (r < 32) kind = SEG_RUN_ON;
        else if (r < 47) kind = SEG_LITERAL;
        else if (r < 51) kind = SEG_LONE_QUOTE;
        else if (r < 63) kind = SEG_FILLER;
        else if (r < 73) kind = SEG_NEWLINE;
        else if (r < 77) kind = SEG_ZERO;
        else if (r < 92) kind = SEG_NOISE;
        else             kind = SEG_END;
        k = $urandom_range(KW_SLOTS - 1);
        case (kind)
            SEG_KEYWORD:
                send_text(tally.keyword_spell[k]);
            SEG_RUN_ON:
            begin
                // Keyword prefix running into a keyword
                cut = $urandom_range(tally.keyword_spell[k].len() - 1, 1);
                send_text(tally.keyword_spell[k].substr(0, cut - 1));
                send_text(tally.keyword_spell[$urandom_range(KW_SLOTS - 1)]);
            end
            SEG_LITERAL:
            begin
                send_item(CHAR_QUOTE, 1'b0);
                send_filler($urandom_range(5));
                if ($urandom_range(2) == 0)
                    send_text(tally.keyword_spell[k]);
                send_filler($urandom_range(5));
                send_item(CHAR_QUOTE, 1'b0);
            end
            SEG_LONE_QUOTE:
                send_item(CHAR_QUOTE, 1'b0);
            SEG_FILLER:
                send_filler($urandom_range(4, 1));
            SEG_NEWLINE:
                send_item(CHAR_NL, 1'b0);
            SEG_ZERO:
                send_item(CHAR_NUL, 1'b0);
            SEG_NOISE:
                repeat ($urandom_range(3, 1))
                    send_item(8'($urandom_range(255)), 1'b0);
            default:
                send_end();
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        bit stalled_once;
        bit drained_once;
        stalled_once = 1'b0;
        drained_once = 1'b0;

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty report, paired and unpaired quotes, all-ones byte,
        // zero byte stopping the chunk, newline restart, keyword inside a word
        send_end();
        send_text("\"ab\"gets");
        send_item(8'hFF, 1'b0);
        send_text("\"c");
        send_item(CHAR_NUL, 1'b0);
        send_text("puts\nsgets");
        send_end();
        wait_drained();

        // Random text with back-pressure, a drain pause and a stretch with no idling
        while (sent_items < ITEM_TARGET)
        begin
            no_idle = (sent_items >= 230 && sent_items < 290);
            if (!stalled_once && sent_items >= 80)
            begin
                stalled_once = 1'b1;
                stall_requests++;
                send_end();
                send_text("gets\"x\"");
                send_end();
                send_end();
            end
            if (!drained_once && sent_items >= 200)
            begin
                drained_once = 1'b1;
                wait_drained();
            end
            send_segment();
        end
        no_idle = 1'b0;

        // Leave an open quote in the chunk, then a final report
        send_text("strlen\"");
        send_end();
        push <= 1'b0;

        // Wait for the remaining rows, then let the block settle
        while (tally.pending_rows.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Covered %0d text bytes in %0d reports, %0d rows checked, %0d quote pairs.",
                 tally.bytes_seen, tally.reports_seen, tally.rows_checked,
                 tally.pairs_reported);
        $display("Keyword hits reported: %0d; input held off by full for %0d cycles.",
                 tally.hits_reported, full_cycles);
        if (tally.errors == 0)
        begin
            $display("keyword_and_literal_counter test passed");
        end
        else
        begin
            $display("%0d mismatches", tally.errors);
            $display("keyword_and_literal_counter test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/kwlc_pkg.sv
design/kwlc_fifo.sv
design/kwlc_front.sv
design/kwlc_back.sv
design/keyword_and_literal_counter.sv
dv/tb.sv
